/* rtl/uksh_pkg.sv */
// Package for the unique-key hash set: sizes, status and command codes,
// controller state type. No dependencies.

package uksh_pkg;

   // Default sizes, handed to the top level as parameter defaults.
   localparam int NUM_BUCKETS  = 16;
   localparam int BUCKET_DEPTH = 8;
   localparam int KEY_BYTES    = 8;

   // Fixed field widths.
   localparam int KEY_W          = 64;
   localparam int STATUS_W       = 3;
   localparam int BUCKET_INDEX_W = 4;

   // Hash datapath: 32-bit polynomial hash, one key byte a step, then
   // reduction modulo the bucket count eight hash bits a step.
   localparam int HASH_W       = 32;
   localparam logic [HASH_W-1:0] HASH_SEED = 32'd1;
   localparam logic [HASH_W-1:0] HASH_MULT = 32'd31;
   localparam int BYTE_W       = 8;
   localparam int STEP_CNT_W   = 3;
   localparam int REM_BITS     = 8;
   localparam int REM_STEPS    = HASH_W / REM_BITS;

   // Command codes.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_FILL_RD,
      ST_FILL_GET,
      ST_SCAN,
      ST_RESOLVE,
      ST_MOVE
   } state_type;

endpackage

/* rtl/uksh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module uksh_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [Width-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/uksh_hash.sv */
// Iterative bucket hash: polynomial hash over the key bytes, then remainder
// by the bucket count. Depends on uksh_pkg.

module uksh_hash #(
   parameter int NumBuckets = uksh_pkg::NUM_BUCKETS,
   parameter int KeyBytes   = uksh_pkg::KEY_BYTES,
   localparam int RemW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [uksh_pkg::KEY_W-1:0] key,
   output logic                       done,
   output logic [RemW-1:0]            bucket
);

   localparam int RemXW = RemW + 1;
   localparam int CntW  = uksh_pkg::STEP_CNT_W;
   localparam int HashW = uksh_pkg::HASH_W;

   logic             run_ff, run_in;
   logic             reduce_ff, reduce_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [HashW-1:0] hash_ff, hash_in;
   logic [RemW-1:0]  rem_ff, rem_in;
   logic [RemW-1:0]  rem_step;
   logic [RemXW-1:0] rem_trial;
   logic [uksh_pkg::BYTE_W-1:0] key_byte;
   logic             last_byte;
   logic             last_rem;

   assign key_byte  = key[{cnt_ff, 3'b000} +: uksh_pkg::BYTE_W];
   assign last_byte = (cnt_ff == CntW'(KeyBytes - 1));
   assign last_rem  = (cnt_ff == CntW'(uksh_pkg::REM_STEPS - 1));

   // Restoring remainder over the top eight hash bits.
   always_comb begin
      rem_step  = rem_ff;
      rem_trial = '0;
      for (int i = 0; i < uksh_pkg::REM_BITS; i++) begin
         rem_trial = {rem_step, hash_ff[HashW-1-i]};
         if (rem_trial >= RemXW'(NumBuckets)) begin
            rem_trial = rem_trial - RemXW'(NumBuckets);
         end
         rem_step = rem_trial[RemW-1:0];
      end
   end

   always_comb begin
      run_in    = run_ff;
      reduce_in = reduce_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      hash_in   = hash_ff;
      rem_in    = rem_ff;
      if (start) begin
         run_in    = 1'b1;
         reduce_in = 1'b0;
         cnt_in    = '0;
         hash_in   = uksh_pkg::HASH_SEED;
         rem_in    = '0;
      end else if (run_ff && !reduce_ff) begin
         hash_in = hash_ff * uksh_pkg::HASH_MULT + HashW'(key_byte);
         if (last_byte) begin
            reduce_in = 1'b1;
            cnt_in    = '0;
         end else begin
            cnt_in = cnt_ff + CntW'(1);
         end
      end else if (run_ff) begin
         rem_in  = rem_step;
         hash_in = hash_ff << uksh_pkg::REM_BITS;
         cnt_in  = cnt_ff + CntW'(1);
         if (last_rem) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         reduce_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         run_ff    <= run_in;
         reduce_ff <= reduce_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

/* rtl/unique_key_hash_set.sv */
// Top level of the unique-key hash set: controller, slot and fill memories.
// Depends on uksh_pkg, uksh_ram and uksh_hash.

// A set of 64-bit keys held in NumBuckets buckets of BucketDepth slots.
// Raise start with req_func (0 insert if absent, 1 remove) and req_key; the
// transaction is taken at an edge where busy is low. Exactly one result
// follows: rsp_strobe is high for a single cycle with rsp_status and
// rsp_bucket_index, and there is no way to hold it off, so sample it then.
// One transaction is in work at a time. The scan reads one slot of the
// bucket a cycle until it finds the key or passes the last filled slot,
// and a removal that moves the last entry adds a move state. The hash
// alone is KeyBytes byte steps and four remainder steps. busy is low again
// in the cycle the strobe is high, so the next transaction can be taken
// then. After reset the block sweeps the fill memory to zero, one bucket a
// cycle, and busy stays high until every bucket has been cleared.

module unique_key_hash_set #(
   parameter int NumBuckets  = uksh_pkg::NUM_BUCKETS,
   parameter int BucketDepth = uksh_pkg::BUCKET_DEPTH,
   parameter int KeyBytes    = uksh_pkg::KEY_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_func,
   input  logic [uksh_pkg::KEY_W-1:0]          req_key,
   output logic                                rsp_strobe,
   output logic [uksh_pkg::STATUS_W-1:0]       rsp_status,
   output logic [uksh_pkg::BUCKET_INDEX_W-1:0] rsp_bucket_index
);

   localparam int BktW   = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
   localparam int FillW  = $clog2(BucketDepth + 1);
   localparam int Slots  = NumBuckets * BucketDepth;
   localparam int SlotAw = (Slots > 1) ? $clog2(Slots) : 1;
   localparam int KeyW   = uksh_pkg::KEY_W;

   uksh_pkg::state_type state_ff, state_in;

   logic                            func_ff, func_in;
   logic [KeyW-1:0]                 key_ff, key_in;
   logic [BktW-1:0]                 bkt_ff, bkt_in;
   logic [FillW-1:0]                fill_ff, fill_in;
   logic [FillW-1:0]                idx_ff, idx_in;
   logic                            cmp_vld_ff, cmp_vld_in;
   logic [FillW-1:0]                cmp_idx_ff, cmp_idx_in;
   logic                            found_ff, found_in;
   logic [FillW-1:0]                found_idx_ff, found_idx_in;
   logic [BktW-1:0]                 clr_ff, clr_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic [uksh_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [BktW-1:0]                 rsp_bkt_ff, rsp_bkt_in;

   logic                            hash_start;
   logic                            hash_done;
   logic [BktW-1:0]                 hash_bucket;

   logic                            slot_we;
   logic [SlotAw-1:0]               slot_waddr;
   logic [KeyW-1:0]                 slot_wdata;
   logic [SlotAw-1:0]               slot_raddr;
   logic [KeyW-1:0]                 slot_rdata;
   logic [SlotAw-1:0]               slot_base;
   logic [FillW-1:0]                slot_rd_idx;

   logic                            fill_we;
   logic [BktW-1:0]                 fill_waddr;
   logic [FillW-1:0]                fill_wdata;
   logic [FillW-1:0]                fill_rdata;

   logic                            hit;
   logic                            more;

   assign busy       = (state_ff != uksh_pkg::ST_IDLE);
   assign hash_start = start && !busy;

   // Bucket base address in the slot memory; the read side scans the bucket
   // and, while resolving, fetches its last entry for a removal.
   assign slot_base   = SlotAw'(bkt_ff) * SlotAw'(BucketDepth);
   assign slot_rd_idx = (state_ff == uksh_pkg::ST_RESOLVE) ? fill_ff - FillW'(1) : idx_ff;
   assign slot_raddr  = slot_base + SlotAw'(slot_rd_idx);
   assign fill_waddr  = (state_ff == uksh_pkg::ST_CLEAR) ? clr_ff : bkt_ff;

   // Compare follows issue in the next cycle: the read data belongs to cmp_idx_ff.
   assign hit  = cmp_vld_ff && (slot_rdata == key_ff);
   assign more = (idx_ff < fill_ff);

   uksh_hash #(
      .NumBuckets (NumBuckets),
      .KeyBytes   (KeyBytes)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (key_ff),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   uksh_ram #(
      .Width (KeyW),
      .Depth (Slots)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   uksh_ram #(
      .Width (FillW),
      .Depth (NumBuckets)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_waddr),
      .wr_data (fill_wdata),
      .rd_addr (bkt_ff),
      .rd_data (fill_rdata)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         uksh_pkg::ST_CLEAR: begin
            if (clr_ff == BktW'(NumBuckets - 1)) begin
               state_in = uksh_pkg::ST_IDLE;
            end
         end
         uksh_pkg::ST_IDLE: begin
            if (start) begin
               state_in = uksh_pkg::ST_HASH;
            end
         end
         uksh_pkg::ST_HASH: begin
            if (hash_done) begin
               state_in = uksh_pkg::ST_FILL_RD;
            end
         end
         uksh_pkg::ST_FILL_RD: begin
            state_in = uksh_pkg::ST_FILL_GET;
         end
         uksh_pkg::ST_FILL_GET: begin
            state_in = uksh_pkg::ST_SCAN;
         end
         uksh_pkg::ST_SCAN: begin
            if (hit || (!cmp_vld_ff && !more)) begin
               state_in = uksh_pkg::ST_RESOLVE;
            end
         end
         uksh_pkg::ST_RESOLVE: begin
            if (func_ff == uksh_pkg::FUNC_REMOVE && found_ff) begin
               state_in = uksh_pkg::ST_MOVE;
            end else begin
               state_in = uksh_pkg::ST_IDLE;
            end
         end
         uksh_pkg::ST_MOVE: begin
            state_in = uksh_pkg::ST_IDLE;
         end
         default: begin
            state_in = uksh_pkg::ST_CLEAR;
         end
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      func_in       = func_ff;
      key_in        = key_ff;
      bkt_in        = bkt_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_bkt_in    = rsp_bkt_ff;
      slot_we       = 1'b0;
      slot_waddr    = slot_base + SlotAw'(fill_ff);
      slot_wdata    = key_ff;
      fill_we       = 1'b0;
      fill_wdata    = fill_ff + FillW'(1);
      unique case (state_ff)
         uksh_pkg::ST_CLEAR: begin
            // Zero one bucket count per cycle.
            fill_we    = 1'b1;
            fill_wdata = '0;
            clr_in     = clr_ff + BktW'(1);
         end
         uksh_pkg::ST_IDLE: begin
            if (start) begin
               func_in = req_func;
               key_in  = req_key;
            end
         end
         uksh_pkg::ST_HASH: begin
            if (hash_done) begin
               bkt_in = hash_bucket;
            end
         end
         uksh_pkg::ST_FILL_RD: begin
         end
         uksh_pkg::ST_FILL_GET: begin
            fill_in    = fill_rdata;
            idx_in     = '0;
            cmp_vld_in = 1'b0;
            found_in   = 1'b0;
         end
         uksh_pkg::ST_SCAN: begin
            // Issue the next slot read while comparing the previous one.
            if (hit) begin
               found_in     = 1'b1;
               found_idx_in = cmp_idx_ff;
               cmp_vld_in   = 1'b0;
            end else if (more) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = idx_ff;
               idx_in     = idx_ff + FillW'(1);
            end else begin
               cmp_vld_in = 1'b0;
            end
         end
         uksh_pkg::ST_RESOLVE: begin
            rsp_bkt_in = bkt_ff;
            if (func_ff == uksh_pkg::FUNC_INSERT) begin
               rsp_strobe_in = 1'b1;
               if (found_ff) begin
                  rsp_status_in = uksh_pkg::STATUS_PRESENT;
               end else if (fill_ff >= FillW'(BucketDepth)) begin
                  rsp_status_in = uksh_pkg::STATUS_FULL;
               end else begin
                  // Append at the end of the bucket.
                  slot_we       = 1'b1;
                  fill_we       = 1'b1;
                  rsp_status_in = uksh_pkg::STATUS_INSERTED;
               end
            end else if (!found_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = uksh_pkg::STATUS_NOT_FOUND;
            end
         end
         uksh_pkg::ST_MOVE: begin
            // Move the last entry into the freed slot and shrink the bucket.
            slot_we       = 1'b1;
            slot_waddr    = slot_base + SlotAw'(found_idx_ff);
            slot_wdata    = slot_rdata;
            fill_we       = 1'b1;
            fill_wdata    = fill_ff - FillW'(1);
            rsp_strobe_in = 1'b1;
            rsp_status_in = uksh_pkg::STATUS_REMOVED;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= uksh_pkg::ST_CLEAR;
         clr_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_ff        <= key_in;
      bkt_ff        <= bkt_in;
      fill_ff       <= fill_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bkt_ff    <= rsp_bkt_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bucket_index = uksh_pkg::BUCKET_INDEX_W'(rsp_bkt_ff);

`ifndef ASSERT_OFF
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_slot_write_updates_fill: assert property (@(posedge clock) disable iff (reset)
      slot_we |-> (fill_we && state_ff != uksh_pkg::ST_CLEAR))
      else $error("slot written without a matching fill update");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == uksh_pkg::ST_RESOLVE) |-> (fill_ff <= FillW'(BucketDepth)))
      else $error("bucket fill count beyond bucket depth");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for unique_key_hash_set: directed and random
// insert/remove transactions checked against an in-bench model of the set.
// Depends on uksh_pkg and the unique_key_hash_set RTL.
`timescale 1ns / 100ps

module tb;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RANDOM_ITEMS   = 1650;
   localparam int PHASE_COUNT    = 4;
   localparam int DRAIN_CYCLES   = 48;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_COUNT = 23;

   // One expected or observed result of a transaction.
   typedef struct packed {
      logic [uksh_pkg::STATUS_W-1:0]       status;
      logic [uksh_pkg::BUCKET_INDEX_W-1:0] bucket;
   } outcome_type;

   // One directed transaction; known marks a result typed in by hand.
   typedef struct packed {
      logic                                func;
      logic [uksh_pkg::KEY_W-1:0]          key;
      logic                                known;
      logic [uksh_pkg::STATUS_W-1:0]       status;
      logic [uksh_pkg::BUCKET_INDEX_W-1:0] bucket;
   } directed_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic                                req_func;
   logic [uksh_pkg::KEY_W-1:0]          req_key;
   logic                                rsp_strobe;
   logic [uksh_pkg::STATUS_W-1:0]       rsp_status;
   logic [uksh_pkg::BUCKET_INDEX_W-1:0] rsp_bucket_index;

   // Model of the set contents: keys per bucket and the fill count of each.
   logic [uksh_pkg::KEY_W-1:0] set_slots [uksh_pkg::NUM_BUCKETS][uksh_pkg::BUCKET_DEPTH];
   int unsigned                set_fill [uksh_pkg::NUM_BUCKETS];

   outcome_type pending_outcomes [$];
   int unsigned error_count;
   int unsigned sent_count;
   int unsigned checked_count;
   int unsigned status_seen [8];
   int unsigned idle_pct;
   int unsigned idle_cycles;

   // Bucket 1 holds key zero, all-ones and any key that is zero but for a top
   // byte that is a multiple of 16, so the rows below can fill it up by hand.
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{uksh_pkg::FUNC_REMOVE, 64'h0000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_NOT_FOUND, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h0000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_INSERTED, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h0000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_PRESENT, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        uksh_pkg::STATUS_INSERTED, 4'd1},
      '{uksh_pkg::FUNC_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        uksh_pkg::STATUS_REMOVED, 4'd1},
      '{uksh_pkg::FUNC_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        uksh_pkg::STATUS_NOT_FOUND, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h1000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_INSERTED, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h2000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_INSERTED, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h3000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_INSERTED, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h4000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_INSERTED, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h5000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_INSERTED, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h6000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_INSERTED, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h7000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_INSERTED, 4'd1},
      // bucket now full: a new key is refused, a stored one still found
      '{uksh_pkg::FUNC_INSERT, 64'h8000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_FULL, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h3000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_PRESENT, 4'd1},
      // remove the first slot, then the last entry that was moved into it
      '{uksh_pkg::FUNC_REMOVE, 64'h0000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_REMOVED, 4'd1},
      '{uksh_pkg::FUNC_REMOVE, 64'h7000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_REMOVED, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h8000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_INSERTED, 4'd1},
      '{uksh_pkg::FUNC_REMOVE, 64'hF000_0000_0000_0000, 1'b1,
        uksh_pkg::STATUS_NOT_FOUND, 4'd1},
      '{uksh_pkg::FUNC_INSERT, 64'h0123_4567_89AB_CDEF, 1'b0,
        uksh_pkg::STATUS_INSERTED, 4'd0},
      '{uksh_pkg::FUNC_INSERT, 64'h8000_0000_0000_0001, 1'b0,
        uksh_pkg::STATUS_INSERTED, 4'd0},
      '{uksh_pkg::FUNC_REMOVE, 64'h0123_4567_89AB_CDEF, 1'b0,
        uksh_pkg::STATUS_INSERTED, 4'd0},
      '{uksh_pkg::FUNC_INSERT, 64'h0000_0000_0000_00FF, 1'b0,
        uksh_pkg::STATUS_INSERTED, 4'd0}
   };

   unique_key_hash_set i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_key          (req_key),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_bucket_index (rsp_bucket_index)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Polynomial hash over the key bytes, least significant byte first.
   function automatic logic [uksh_pkg::HASH_W-1:0] key_hash(
      input logic [uksh_pkg::KEY_W-1:0] key);
      logic [uksh_pkg::HASH_W-1:0] h;
      h = uksh_pkg::HASH_SEED;
      for (int b = 0; b < uksh_pkg::KEY_BYTES; b++)
         h = h * uksh_pkg::HASH_MULT
             + uksh_pkg::HASH_W'(key[b*uksh_pkg::BYTE_W +: uksh_pkg::BYTE_W]);
      return h;
   endfunction

   function automatic int unsigned key_bucket(input logic [uksh_pkg::KEY_W-1:0] key);
      return key_hash(key) % uksh_pkg::NUM_BUCKETS;
   endfunction

   // Apply one insert or remove to the model set and return its outcome.
   function automatic outcome_type apply_set_op(input logic func,
                                                input logic [uksh_pkg::KEY_W-1:0] key);
      int unsigned bkt;
      int unsigned fill;
      int unsigned pos;
      logic        hit;
      outcome_type res;
      bkt  = key_bucket(key);
      fill = set_fill[bkt];
      hit  = 1'b0;
      pos  = 0;
      for (int i = 0; i < fill; i++) begin
         if (!hit && set_slots[bkt][i] == key) begin
            hit = 1'b1;
            pos = i;
         end
      end
      if (func == uksh_pkg::FUNC_INSERT) begin
         if (hit) begin
            res.status = uksh_pkg::STATUS_PRESENT;
         end else if (fill >= uksh_pkg::BUCKET_DEPTH) begin
            res.status = uksh_pkg::STATUS_FULL;
         end else begin
            set_slots[bkt][fill] = key;
            set_fill[bkt] = fill + 1;
            res.status = uksh_pkg::STATUS_INSERTED;
         end
      end else begin
         if (hit) begin
            // back-fill the hole with the bucket's last entry
            set_slots[bkt][pos] = set_slots[bkt][fill-1];
            set_fill[bkt] = fill - 1;
            res.status = uksh_pkg::STATUS_REMOVED;
         end else begin
            res.status = uksh_pkg::STATUS_NOT_FOUND;
         end
      end
      res.bucket = uksh_pkg::BUCKET_INDEX_W'(bkt);
      return res;
   endfunction

   // Random key steered into a given bucket through the low nibble of the
   // top byte: that byte is added last, and 16 divides 2**32.
   function automatic logic [uksh_pkg::KEY_W-1:0] key_in_bucket(input int unsigned bkt);
      logic [uksh_pkg::KEY_W-1:0]  k;
      logic [uksh_pkg::HASH_W-1:0] h;
      k = {$urandom, $urandom};
      k[uksh_pkg::KEY_W-1 -: uksh_pkg::BYTE_W] = '0;
      h = key_hash(k);
      k[uksh_pkg::KEY_W-uksh_pkg::BYTE_W +: 4] = 4'(bkt - h);
      k[uksh_pkg::KEY_W-4 +: 4] = 4'($urandom);
      return k;
   endfunction

   // Pick a key currently held in the model set, or a random one if empty.
   function automatic logic [uksh_pkg::KEY_W-1:0] stored_key();
      int unsigned total;
      int unsigned pick;
      total = 0;
      foreach (set_fill[b]) total += set_fill[b];
      if (total == 0) return {$urandom, $urandom};
      pick = $urandom_range(total - 1);
      foreach (set_fill[b]) begin
         if (pick < set_fill[b]) return set_slots[b][pick];
         pick -= set_fill[b];
      end
      return {$urandom, $urandom};
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Drive one transaction from a falling edge, hold it until taken, and
   // log what the set should answer. Returns at the following falling edge
   // with start still high.
   task automatic send_item(input logic func, input logic [uksh_pkg::KEY_W-1:0] key,
                            input logic known, input outcome_type typed);
      outcome_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         start    <= 1'b0;
         req_func <= 1'($urandom);
         req_key  <= {$urandom, $urandom};
         @(negedge clock);
      end
      start    <= 1'b1;
      req_func <= func;
      req_key  <= key;
      do @(posedge clock); while (busy);
      predicted = apply_set_op(func, key);
      pending_outcomes.push_back(known ? typed : predicted);
      sent_count++;
      @(negedge clock);
   endtask

   // Check every result against the oldest expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_strobe) begin
         status_seen[rsp_status]++;
         checked_count++;
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d bucket %0d",
                                      rsp_status, rsp_bucket_index));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d (bucket %0d)",
                                         rsp_status, want.status, want.bucket));
            if (rsp_bucket_index !== want.bucket)
               report_mismatch($sformatf("bucket %0d, expected %0d",
                                         rsp_bucket_index, want.bucket));
         end
      end
   end

   // Watchdog: give up when neither side moves a transaction for too long.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      outcome_type typed;
      outcome_type dont_care;
      logic        func;
      logic [uksh_pkg::KEY_W-1:0] key;
      int unsigned roll;
      int unsigned bkt;

      reset    = 1'b1;
      start    = 1'b0;
      req_func = uksh_pkg::FUNC_INSERT;
      req_key  = '0;
      error_count   = 0;
      sent_count    = 0;
      checked_count = 0;
      idle_pct      = 0;
      dont_care     = '0;
      foreach (status_seen[s]) status_seen[s] = 0;
      foreach (set_fill[b]) set_fill[b] = 0;

      // Hold reset high, then release it at a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the table back to back.
      foreach (directed_rows[r]) begin
         typed.status = directed_rows[r].status;
         typed.bucket = directed_rows[r].bucket;
         send_item(directed_rows[r].func, directed_rows[r].key,
                   directed_rows[r].known, typed);
      end

      // Random part, in phases of sender pacing: none, heavy, none, light.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ((n * PHASE_COUNT) / RANDOM_ITEMS)
            0: idle_pct = 0;
            1: idle_pct = 80;
            2: idle_pct = 0;
            default: idle_pct = 32;
         endcase
         roll = $urandom_range(99);
         // crowd a few hot buckets half the time so they fill up
         bkt = $urandom_range(1) ? $urandom_range(3)
                                 : $urandom_range(uksh_pkg::NUM_BUCKETS - 1);
         if (roll < 40) begin
            func = uksh_pkg::FUNC_INSERT;
            key  = key_in_bucket(bkt);
         end else if (roll < 55) begin
            func = uksh_pkg::FUNC_INSERT;
            key  = stored_key();
         end else if (roll < 80) begin
            func = uksh_pkg::FUNC_REMOVE;
            key  = stored_key();
         end else if (roll < 90) begin
            func = uksh_pkg::FUNC_REMOVE;
            key  = key_in_bucket(bkt);
         end else begin
            func = 1'($urandom);
            key  = {$urandom, $urandom};
         end
         send_item(func, key, 1'b0, dont_care);
      end

      // Drop start, drain outstanding results, then allow for the latency.
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transactions sent, %0d results checked, %0d mismatches",
               sent_count, checked_count, error_count);
      $display("inserted %0d, present %0d, full %0d, removed %0d, not found %0d",
               status_seen[uksh_pkg::STATUS_INSERTED],
               status_seen[uksh_pkg::STATUS_PRESENT],
               status_seen[uksh_pkg::STATUS_FULL],
               status_seen[uksh_pkg::STATUS_REMOVED],
               status_seen[uksh_pkg::STATUS_NOT_FOUND]);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
